### src/nvs_pkg.sv
package nvs_pkg;

	localparam int MaxVertices = 1024;
	localparam int CoordBits = 24;
	localparam int IdxBits = $clog2(MaxVertices);
	localparam int CntBits = $clog2(MaxVertices + 1);
	localparam int StepBits = 23;
	localparam int MagBits = CoordBits + 1;
	localparam int SqBits = 2 * MagBits + 1;
	localparam int OffBits = 23;

	localparam logic OP_ADD = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic op;
		logic signed [CoordBits-1:0] point_x;
		logic signed [CoordBits-1:0] point_y;
	} in_word_t;

	typedef struct packed {
		logic found;
		logic [9:0] nearest_index;
		logic signed [CoordBits-1:0] new_x;
		logic signed [CoordBits-1:0] new_y;
		logic added;
		logic store_full;
		logic [10:0] vertex_count;
	} out_word_t;

	// Request from the controller to the steering unit.
	typedef struct packed {
		logic start;
		logic [MagBits-1:0] mag;
		logic [SqBits-1:0] d2;
		logic [StepBits-1:0] step;
	} steer_req_t;

	typedef struct packed {
		logic done;
		logic [OffBits-1:0] offset;
	} steer_rsp_t;

endpackage

### src/nvs_vertex_mem.sv
// Vertex store: one write port, one read port, registered read data.
module nvs_vertex_mem (
	input  logic clk,
	input  logic wr_en,
	input  logic [nvs_pkg::IdxBits-1:0] wr_addr,
	input  logic [2*nvs_pkg::CoordBits-1:0] wr_data,
	input  logic [nvs_pkg::IdxBits-1:0] rd_addr,
	output logic [2*nvs_pkg::CoordBits-1:0] rd_data
);

	logic [2*nvs_pkg::CoordBits-1:0] mem_q [nvs_pkg::MaxVertices];

	// Write and read in the same clocked block.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

### src/nvs_steer_unit.sv
// Finds the largest m <= step with m*m*d2 <= mag*mag*step*step, one bit a pass.
// The wide products are built from four partial products, one per cycle.
// The target is multiplied out once per run. Each bit then squares the candidate,
// scales it by d2 through the four partial products, and compares.
module nvs_steer_unit (
	input  logic clk,
	input  logic arst_n,
	input  nvs_pkg::steer_req_t req,
	output nvs_pkg::steer_rsp_t rsp
);

	localparam int ProdBits = 2 * nvs_pkg::OffBits + nvs_pkg::SqBits;
	localparam int BitW = $clog2(nvs_pkg::OffBits);
	localparam int MagSqBits = 2 * nvs_pkg::MagBits;
	localparam int CsqBits = 2 * nvs_pkg::OffBits;
	localparam int HalfA = (nvs_pkg::SqBits + 1) / 2;
	localparam int PartBits = HalfA + nvs_pkg::OffBits;

	typedef enum logic [2:0] {S_IDLE, S_T1, S_T2, S_TM, S_SQ, S_MUL, S_CMP} state_t;

	state_t state_q;
	logic [BitW-1:0] bit_q;
	logic [nvs_pkg::OffBits-1:0] m_q;
	logic [nvs_pkg::MagBits-1:0] mag_q;
	logic [nvs_pkg::SqBits-1:0] d2_q;
	logic [nvs_pkg::StepBits-1:0] step_q;
	logic [MagSqBits-1:0] magsq_q;
	logic [ProdBits-1:0] target_q;
	logic [nvs_pkg::SqBits-1:0] mul_a_q;
	logic [CsqBits-1:0] mul_b_q;
	logic [ProdBits-1:0] acc_q;
	logic [1:0] part_q;
	logic [HalfA-1:0] part_a;
	logic [nvs_pkg::OffBits-1:0] part_b;
	logic [PartBits-1:0] part_p;
	logic [ProdBits-1:0] part_sh;
	logic [ProdBits-1:0] acc_next;
	logic [nvs_pkg::OffBits-1:0] cand;
	logic done_q;

	assign cand = m_q | (nvs_pkg::OffBits'(1) << bit_q);

	// One partial product of mul_a_q * mul_b_q per cycle, shifted into place.
	always_comb begin
		part_a = part_q[1] ? HalfA'(mul_a_q[nvs_pkg::SqBits-1:HalfA]) : mul_a_q[HalfA-1:0];
		part_b = part_q[0] ? mul_b_q[CsqBits-1:nvs_pkg::OffBits]
			: mul_b_q[nvs_pkg::OffBits-1:0];
		part_p = PartBits'(part_a) * PartBits'(part_b);
		case (part_q)
			2'd0: part_sh = ProdBits'(part_p);
			2'd1: part_sh = ProdBits'(part_p) << nvs_pkg::OffBits;
			2'd2: part_sh = ProdBits'(part_p) << HalfA;
			default: part_sh = ProdBits'(part_p) << (HalfA + nvs_pkg::OffBits);
		endcase
		acc_next = acc_q + part_sh;
	end

	// Target is built once, then the bit loop runs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (req.start) begin
						mag_q <= req.mag;
						d2_q <= req.d2;
						step_q <= req.step;
						m_q <= '0;
						bit_q <= BitW'(nvs_pkg::OffBits - 1);
						state_q <= S_T1;
					end
				end
				S_T1: begin
					magsq_q <= MagSqBits'(mag_q) * MagSqBits'(mag_q);
					mul_b_q <= CsqBits'(step_q) * CsqBits'(step_q);
					state_q <= S_T2;
				end
				S_T2: begin
					mul_a_q <= nvs_pkg::SqBits'(magsq_q);
					acc_q <= '0;
					part_q <= '0;
					state_q <= S_TM;
				end
				S_TM: begin
					acc_q <= acc_next;
					part_q <= part_q + 1'b1;
					if (part_q == 2'd3) begin
						target_q <= acc_next;
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					mul_a_q <= d2_q;
					mul_b_q <= CsqBits'(cand) * CsqBits'(cand);
					acc_q <= '0;
					part_q <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					acc_q <= acc_next;
					part_q <= part_q + 1'b1;
					if (part_q == 2'd3) begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (cand <= nvs_pkg::OffBits'(step_q) && acc_q <= target_q) begin
						m_q <= cand;
					end
					if (bit_q == '0) begin
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						bit_q <= bit_q - 1'b1;
						state_q <= S_SQ;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.offset = m_q;

`ifndef SYNTH
	a_done_from_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q) == S_CMP) else $error("done outside compare");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_T1) |-> $past(state_q) == S_IDLE) else $error("bad start");
	a_m_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> m_q <= nvs_pkg::OffBits'(step_q)) else $error("m over step");
`endif

endmodule

### src/nearest_vertex_steer.sv
// Nearest-vertex search and steering over a store of up to 1024 2-D vertices.
// An add word is answered from the idle state. A query reads the vertex memory
// one entry per cycle; its result word carries the sample itself as the new point
// when the nearest vertex lies within step_length. Otherwise the shared steering
// unit runs twice, once per axis, each run multiplying out the target and then
// deciding 23 bits. One word is in flight at a time; the result register frees
// the input side once the result is taken. The user writes step_length through
// cfg_valid/cfg_ready while the block is idle; the block does not enforce this.
module nearest_vertex_steer (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  nvs_pkg::in_word_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output nvs_pkg::out_word_t out_data,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [nvs_pkg::StepBits-1:0] cfg_data
);

	localparam int CB = nvs_pkg::CoordBits;
	localparam int MB = nvs_pkg::MagBits;
	localparam int QB = nvs_pkg::SqBits;

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN, S_DIFF, S_SQ, S_SUM, S_FETCH, S_FWAIT, S_CHK,
		S_STX, S_WX, S_STY, S_WY, S_OUT
	} state_t;

	state_t state_q;
	logic [nvs_pkg::StepBits-1:0] step_q;
	logic [nvs_pkg::CntBits-1:0] count_q;
	logic signed [CB-1:0] px_q, py_q;
	logic [nvs_pkg::CntBits-1:0] rd_q;
	// Pipeline of the scan.
	logic v_s1, v_s2, v_s3;
	logic [nvs_pkg::IdxBits-1:0] idx_s1, idx_s2, idx_s3;
	logic [MB-1:0] ax_s2, ay_s2;
	logic [2*MB-1:0] sx_s3, sy_s3;
	logic [QB-1:0] best_d2_q;
	logic [nvs_pkg::IdxBits-1:0] best_q;
	logic have_q;
	logic signed [CB:0] dx_q, dy_q;
	logic signed [CB-1:0] vx_q, vy_q;
	logic [nvs_pkg::OffBits-1:0] ox_q;
	logic out_valid_q;
	nvs_pkg::out_word_t out_q;
	nvs_pkg::out_word_t idle_word;
	logic [2*CB-1:0] rd_data;
	logic [nvs_pkg::IdxBits-1:0] rd_addr;
	logic has_room;
	logic mem_we;
	logic signed [CB-1:0] mx, my;
	logic signed [CB:0] ex, ey;
	logic [QB-1:0] d2_new;
	logic [2*nvs_pkg::StepBits-1:0] step_sq;
	nvs_pkg::steer_req_t sreq;
	nvs_pkg::steer_rsp_t srsp;
	logic in_acc;

	assign in_acc = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE) || out_valid_q;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	assign has_room = count_q < nvs_pkg::CntBits'(nvs_pkg::MaxVertices);
	assign mem_we = in_acc && in_data.op == nvs_pkg::OP_ADD && has_room;
	assign rd_addr = (state_q == S_FETCH) ? best_q : rd_q[nvs_pkg::IdxBits-1:0];

	nvs_vertex_mem u_mem (
		.clk(clk), .wr_en(mem_we), .wr_addr(count_q[nvs_pkg::IdxBits-1:0]),
		.wr_data({in_data.point_x, in_data.point_y}),
		.rd_addr(rd_addr), .rd_data(rd_data)
	);

	// Result word for an add or for a query on an empty store.
	always_comb begin
		idle_word = '0;
		idle_word.vertex_count = 11'(count_q);
		if (in_data.op == nvs_pkg::OP_ADD) begin
			if (has_room) begin
				idle_word.added = 1'b1;
				idle_word.vertex_count = 11'(count_q + 1'b1);
			end else begin
				idle_word.store_full = 1'b1;
			end
		end
	end

	// Differences of the vertex just read against the sample.
	assign mx = rd_data[2*CB-1:CB];
	assign my = rd_data[CB-1:0];
	assign ex = (CB+1)'(px_q) - (CB+1)'(mx);
	assign ey = (CB+1)'(py_q) - (CB+1)'(my);
	assign d2_new = QB'(sx_s3) + QB'(sy_s3);
	assign step_sq = (2*nvs_pkg::StepBits)'(step_q) * (2*nvs_pkg::StepBits)'(step_q);

	assign sreq.start = (state_q == S_STX) || (state_q == S_STY);
	assign sreq.mag = (state_q == S_STX) ? MB'(dx_q[CB] ? -dx_q : dx_q)
		: MB'(dy_q[CB] ? -dy_q : dy_q);
	assign sreq.d2 = best_d2_q;
	assign sreq.step = step_q;

	nvs_steer_unit u_steer (.clk(clk), .arst_n(arst_n), .req(sreq), .rsp(srsp));

	// Main sequencer with scan pipeline and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q <= nvs_pkg::StepBits'(256);
			count_q <= '0;
			out_valid_q <= 1'b0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			have_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				step_q <= cfg_data;
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q) inside
				S_IDLE: begin
					if (in_acc) begin
						px_q <= in_data.point_x;
						py_q <= in_data.point_y;
						out_q <= idle_word;
						if (in_data.op == nvs_pkg::OP_ADD) begin
							if (has_room) begin
								count_q <= count_q + 1'b1;
							end
							out_valid_q <= 1'b1;
						end else if (count_q == '0) begin
							out_valid_q <= 1'b1;
						end else begin
							rd_q <= '0;
							have_q <= 1'b0;
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN, S_DIFF, S_SQ, S_SUM: begin
					// Address issue, then three pipeline stages behind the memory.
					v_s1 <= (state_q == S_SCAN);
					idx_s1 <= rd_q[nvs_pkg::IdxBits-1:0];
					if (state_q == S_SCAN) begin
						rd_q <= rd_q + 1'b1;
						if (rd_q + 1'b1 == count_q) state_q <= S_DIFF;
					end else if (state_q == S_DIFF) begin
						state_q <= S_SQ;
					end else if (state_q == S_SQ) begin
						state_q <= S_SUM;
					end else begin
						state_q <= S_FETCH;
					end
					v_s2 <= v_s1;
					idx_s2 <= idx_s1;
					ax_s2 <= MB'(ex[CB] ? -ex : ex);
					ay_s2 <= MB'(ey[CB] ? -ey : ey);
					v_s3 <= v_s2;
					idx_s3 <= idx_s2;
					sx_s3 <= ax_s2 * ax_s2;
					sy_s3 <= ay_s2 * ay_s2;
					if (v_s3 && (!have_q || d2_new < best_d2_q)) begin
						best_d2_q <= d2_new;
						best_q <= idx_s3;
						have_q <= 1'b1;
					end
				end
				S_FETCH: begin
					if (v_s3 && (!have_q || d2_new < best_d2_q)) begin
						best_d2_q <= d2_new;
						best_q <= idx_s3;
						have_q <= 1'b1;
					end
					v_s1 <= 1'b0;
					v_s2 <= 1'b0;
					v_s3 <= 1'b0;
					state_q <= S_FWAIT;
				end
				S_FWAIT: begin
					vx_q <= mx;
					vy_q <= my;
					dx_q <= ex;
					dy_q <= ey;
					state_q <= S_CHK;
				end
				S_CHK: begin
					// Within reach the sample itself is the new point.
					if (best_d2_q <= QB'(step_sq)) begin
						out_q <= '{found: 1'b1, nearest_index: 10'(best_q),
							new_x: px_q, new_y: py_q, added: 1'b0, store_full: 1'b0,
							vertex_count: out_q.vertex_count};
						state_q <= S_OUT;
					end else begin
						state_q <= S_STX;
					end
				end
				S_STX: state_q <= S_WX;
				S_WX: begin
					if (srsp.done) begin
						ox_q <= srsp.offset;
						state_q <= S_STY;
					end
				end
				S_STY: state_q <= S_WY;
				S_WY: begin
					if (srsp.done) begin
						out_q <= '{found: 1'b1, nearest_index: 10'(best_q),
							new_x: dx_q[CB] ? vx_q - CB'(ox_q) : vx_q + CB'(ox_q),
							new_y: dy_q[CB] ? vy_q - CB'(srsp.offset)
								: vy_q + CB'(srsp.offset),
							added: 1'b0, store_full: 1'b0,
							vertex_count: out_q.vertex_count};
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					out_valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= nvs_pkg::CntBits'(nvs_pkg::MaxVertices)) else $error("count overflow");
	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> state_q == S_IDLE) else $error("busy with result pending");
	a_best_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHK) |-> (nvs_pkg::CntBits'(best_q) < count_q && have_q))
		else $error("best index out of range");
	a_count_add: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> $past(mem_we)) else $error("count moved");
`endif

endmodule

### tb/tb_nearest_vertex_steer.sv
`timescale 1ns / 1ps

module tb_nearest_vertex_steer;

	import nvs_pkg::*;

	localparam int StallLimit = 20000;

	// Keeps its own copy of the vertex store and the step length.
	// It predicts one result word per accepted input word and checks the
	// results in order against those predictions.
	class steer_scoreboard;
		longint vtx_x[MaxVertices];
		longint vtx_y[MaxVertices];
		int count;
		longint step;
		out_word_t expected_words[$];
		int errors;

		function new();
			count = 0;
			step = 256;
			errors = 0;
		endfunction

		// Largest offset m <= step with m * dist <= step * mag, found bit by bit.
		function longint steer_offset(longint mag, longint d2);
			bit [127:0] tgt;
			bit [127:0] lhs;
			longint m;
			longint c;
			tgt = 128'(mag) * 128'(mag) * 128'(step) * 128'(step);
			m = 0;
			for (int b = 22; b >= 0; b--) begin
				c = m | (longint'(1) << b);
				lhs = 128'(d2) * 128'(c) * 128'(c);
				if (c <= step && lhs <= tgt)
					m = c;
			end
			return m;
		endfunction

		function void note_input(in_word_t w);
			out_word_t r;
			longint px, py, dx, dy, d2, best_d2, vx, vy, ox, oy;
			int best;
			r = '0;
			px = w.point_x;
			py = w.point_y;
			if (w.op == OP_ADD) begin
				if (count < MaxVertices) begin
					vtx_x[count] = px;
					vtx_y[count] = py;
					count++;
					r.added = 1'b1;
				end else begin
					r.store_full = 1'b1;
				end
			end else if (count > 0) begin
				// Nearest vertex; a strictly smaller distance wins, so ties keep the lowest index.
				best = 0;
				best_d2 = 0;
				for (int i = 0; i < count; i++) begin
					dx = px - vtx_x[i];
					dy = py - vtx_y[i];
					d2 = dx * dx + dy * dy;
					if (i == 0 || d2 < best_d2) begin
						best_d2 = d2;
						best = i;
					end
				end
				r.found = 1'b1;
				r.nearest_index = 10'(best);
				vx = vtx_x[best];
				vy = vtx_y[best];
				dx = px - vx;
				dy = py - vy;
				if (best_d2 <= step * step) begin
					r.new_x = w.point_x;
					r.new_y = w.point_y;
				end else begin
					ox = steer_offset(dx < 0 ? -dx : dx, best_d2);
					oy = steer_offset(dy < 0 ? -dy : dy, best_d2);
					r.new_x = CoordBits'(dx < 0 ? vx - ox : vx + ox);
					r.new_y = CoordBits'(dy < 0 ? vy - oy : vy + oy);
				end
			end
			r.vertex_count = 11'(count);
			expected_words = {expected_words, r};
		endfunction

		function void check_result(out_word_t act);
			out_word_t e;
			if (expected_words.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("ERROR: result word with none expected: %h", act);
				return;
			end
			e = expected_words.pop_front();
			if (act.found != e.found || act.nearest_index != e.nearest_index ||
			    act.new_x != e.new_x || act.new_y != e.new_y ||
			    act.added != e.added || act.store_full != e.store_full ||
			    act.vertex_count != e.vertex_count) begin
				errors++;
				if (errors <= 10)
					$display({"ERROR: found %0d/%0d idx %0d/%0d x %0d/%0d y %0d/%0d ",
						"added %0d/%0d full %0d/%0d count %0d/%0d (exp/act)"},
						e.found, act.found, e.nearest_index, act.nearest_index,
						e.new_x, act.new_x, e.new_y, act.new_y, e.added, act.added,
						e.store_full, act.store_full, e.vertex_count, act.vertex_count);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_word_t in_data;
	logic out_valid;
	logic out_stall;
	out_word_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [StepBits-1:0] cfg_data;

	steer_scoreboard sb;
	int idle_pct;
	int stall_pct;
	int quiet_cycles;

	nearest_vertex_steer dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	// The receiver stalls at random; the stall changes only at the falling edge.
	always @(negedge clk) begin
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// Check every result word taken at a rising edge.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(out_data);
	end

	// Watchdog on cycles in which no word moves on any channel.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready) ||
		    !arst_n) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= StallLimit) begin
				$display("FAIL nearest_vertex_steer");
				$finish;
			end
		end
	end

	function automatic logic [CoordBits-1:0] pick_coord();
		case ($urandom_range(0, 5))
			0: return CoordBits'($urandom);
			1: return CoordBits'(int'($urandom_range(0, 4095)) - 2048);
			2: begin
				case ($urandom_range(0, 3))
					0: return {1'b1, {(CoordBits-1){1'b0}}};
					1: return {1'b0, {(CoordBits-1){1'b1}}};
					2: return '0;
					default: return '1;
				endcase
			end
			default: return CoordBits'(int'($urandom_range(0, 131071)) - 65536);
		endcase
	endfunction

	// Offer one word; it is taken at the first rising edge without a stall.
	task automatic send_word(logic op, logic [CoordBits-1:0] x, logic [CoordBits-1:0] y);
		in_word_t w;
		w.op = op;
		w.point_x = x;
		w.point_y = y;
		@(negedge clk);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_data = w;
		do @(posedge clk); while (in_stall);
		sb.note_input(w);
	endtask

	// Let every expected word arrive, then write step_length.
	task automatic write_step(logic [StepBits-1:0] value);
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.expected_words.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		sb.step = value;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Mostly queries; adds keep the store growing slowly.
	task automatic random_words(int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < 30 || sb.count == 0)
				send_word(OP_ADD, pick_coord(), pick_coord());
			else
				send_word(OP_QUERY, pick_coord(), pick_coord());
		end
	endtask

	initial begin
		sb = new();
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		idle_pct = 0;
		stall_pct = 0;
		quiet_cycles = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed words: empty store, extremes, a tie and both steering cases.
		send_word(OP_QUERY, 24'sd100, -24'sd100);
		send_word(OP_ADD, 24'sd0, 24'sd0);
		send_word(OP_ADD, 24'sd512, 24'sd0);
		send_word(OP_QUERY, 24'sd256, 24'sd0);
		send_word(OP_QUERY, 24'sd100, 24'sd50);
		send_word(OP_QUERY, 24'sd3000, -24'sd4000);
		send_word(OP_ADD, 24'sd0, 24'sd0);
		send_word(OP_QUERY, 24'sd0, 24'sd0);
		send_word(OP_ADD, {1'b1, 23'd0}, {1'b1, 23'd0});
		send_word(OP_ADD, {1'b0, {23{1'b1}}}, {1'b0, {23{1'b1}}});
		send_word(OP_QUERY, {1'b1, 23'd0}, {1'b0, {23{1'b1}}});
		send_word(OP_QUERY, {1'b0, {23{1'b1}}}, {1'b1, 23'd0});
		send_word(OP_QUERY, -24'sd1, -24'sd1);
		write_step('0);
		send_word(OP_QUERY, 24'sd700, 24'sd9);
		send_word(OP_QUERY, 24'sd512, 24'sd0);
		write_step({StepBits{1'b1}});
		send_word(OP_QUERY, {1'b1, 23'd0}, {1'b0, {23{1'b1}}});
		send_word(OP_QUERY, 24'sd12345, -24'sd999);
		write_step(23'd1);
		send_word(OP_QUERY, 24'sd7, 24'sd5);

		// Random words under each idling pattern and several step lengths.
		write_step(23'd256);
		random_words(140);
		idle_pct = 76;
		write_step(23'($urandom_range(1, 4096)));
		random_words(140);
		idle_pct = 0;
		stall_pct = 76;
		write_step(23'($urandom));
		random_words(140);
		idle_pct = 26;
		stall_pct = 26;
		write_step(23'($urandom_range(0, 65535)));
		random_words(140);

		// A few last words, most of them under the extreme step lengths.
		idle_pct = 0;
		stall_pct = 0;
		send_word(OP_QUERY, pick_coord(), pick_coord());
		write_step({StepBits{1'b1}});
		send_word(OP_QUERY, pick_coord(), pick_coord());
		write_step('0);
		send_word(OP_QUERY, pick_coord(), pick_coord());
		send_word(OP_ADD, 24'sd3, -24'sd3);

		@(negedge clk);
		in_valid = 1'b0;
		while (sb.expected_words.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (sb.errors == 0)
			$display("PASS nearest_vertex_steer");
		else
			$display("FAIL nearest_vertex_steer");
		$finish;
	end

endmodule

### nearest_vertex_steer.f
src/nvs_pkg.sv
src/nvs_vertex_mem.sv
src/nvs_steer_unit.sv
src/nearest_vertex_steer.sv
tb/tb_nearest_vertex_steer.sv
